@@ design/bst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;

  // fixed field widths of the channels
  localparam int FUNC_W    = 2;
  localparam int ELEM_IN_W = 32;
  localparam int COUNT_W   = 5;

  // table index and fill count widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [FUNC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_QUERY  = 2'd2;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // table port request from the sequencer
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    elem_t wdata;
    idx_t  raddr;
  } store_req_t;

endpackage

`default_nettype wire

@@ design/bst_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bst_in_if;
  logic                         valid;
  logic                         ready;
  logic [bst_pkg::FUNC_W-1:0]    func;
  logic [bst_pkg::ELEM_IN_W-1:0] element;

  modport source (output valid, output func, output element, input ready);
  modport sink   (input valid, input func, input element, output ready);
endinterface

interface bst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          was_member;
  logic                          dropped_full;
  logic [bst_pkg::COUNT_W-1:0]   set_count;
  logic [bst_pkg::ELEM_IN_W-1:0] oldest_element;
  logic                          is_empty;

  modport source (output valid, output was_member, output dropped_full, output set_count,
                  output oldest_element, output is_empty, input ready);
  modport sink   (input valid, input was_member, input dropped_full, input set_count,
                  input oldest_element, input is_empty, output ready);
endinterface

`default_nettype wire

@@ design/bst_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// element table: one write port, one read port, registered read data
module bst_store (
  input  wire logic                clk,
  input  wire bst_pkg::store_req_t req,
  output bst_pkg::elem_t           rd_data
);

  bst_pkg::elem_t mem [bst_pkg::CAPACITY];
  bst_pkg::elem_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/bounded_set_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered set. Each input beat on in_ch carries an operation
// (add, remove, query; code 3 acts as query) and an element. Every input
// beat produces exactly one beat on out_ch: was_member, dropped_full,
// set_count, oldest_element (0 when empty) and is_empty.
// Elements live in a CAPACITY-entry table kept in insertion order.
// One comparator walks the table an entry per cycle; a remove then moves
// the later entries down one per cycle through the same table port.
// Each item is searched in S_SEARCH, shifted in S_SHIFT on a remove that
// hits before the last entry, and has its result loaded from S_FIN.
// in_ch.ready is high only while the sequencer is idle, so one item is in
// work at a time and the next is taken in the cycle after the load.
// The result sits in an output register; a new item is accepted while it
// waits. If out_ch stalls, the next item finishes its work and then holds
// until the output register frees up.
// Reset (rst_n low, synchronous) empties the set and drops any pending
// result; table contents are not cleared, only the fill count.
module bounded_set_table_unit (
  input wire logic clk,
  input wire logic rst_n,
  bst_in_if.sink   in_ch,
  bst_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [bst_pkg::FUNC_W-1:0]  func_r;
  bst_pkg::elem_t              elem_r;
  bst_pkg::idx_t               idx_r, idx_nxt;
  bst_pkg::cnt_t               fill_r, fill_nxt;
  bst_pkg::elem_t              oldest_r, oldest_nxt;
  logic                        hit_r, hit_nxt;
  logic                        drop_r, drop_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_was_member_r;
  logic                          out_dropped_full_r;
  logic [bst_pkg::COUNT_W-1:0]   out_set_count_r;
  logic [bst_pkg::ELEM_IN_W-1:0] out_oldest_element_r;
  logic                          out_is_empty_r;

  bst_pkg::store_req_t req;
  bst_pkg::elem_t      rd_data;
  bst_pkg::cnt_t       idx_inc;
  logic                in_fire;
  logic                out_load;
  logic                match;
  logic                scan_end;

  bst_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign idx_inc  = bst_pkg::CNT_W'(idx_r) + bst_pkg::CNT_W'(1);
  assign match    = (fill_r != '0) && (rd_data == elem_r);
  assign scan_end = (fill_r == '0) || (idx_inc == fill_r);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    hit_nxt    = hit_r;
    drop_nxt   = drop_r;
    req.we     = 1'b0;
    req.waddr  = idx_r;
    req.wdata  = elem_r;
    req.raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        // read of entry 0 is issued here so SEARCH sees it next cycle
        if (in_fire) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match) begin
          hit_nxt = 1'b1;
          if (func_r == bst_pkg::OP_REMOVE) begin
            if (idx_inc < fill_r) begin
              req.raddr = bst_pkg::IDX_W'(idx_inc);
              state_nxt = S_SHIFT;
            end else begin
              fill_nxt  = fill_r - bst_pkg::CNT_W'(1);
              state_nxt = S_FIN;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end else if (scan_end) begin
          // miss: append on add if there is room
          if (func_r == bst_pkg::OP_ADD) begin
            if (fill_r < bst_pkg::CNT_W'(bst_pkg::CAPACITY)) begin
              req.we    = 1'b1;
              req.waddr = bst_pkg::IDX_W'(fill_r);
              fill_nxt  = fill_r + bst_pkg::CNT_W'(1);
              if (fill_r == '0) begin
                oldest_nxt = elem_r;
              end
            end else begin
              drop_nxt = 1'b1;
            end
          end
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = bst_pkg::IDX_W'(idx_inc);
          req.raddr = bst_pkg::IDX_W'(idx_inc);
        end
      end
      S_SHIFT: begin
        // rd_data holds entry idx+1; move it down to idx
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = rd_data;
        if (idx_r == '0) begin
          oldest_nxt = rd_data;
        end
        if ((idx_inc + bst_pkg::CNT_W'(1)) < fill_r) begin
          req.raddr = bst_pkg::IDX_W'(idx_inc + bst_pkg::CNT_W'(1));
          idx_nxt   = bst_pkg::IDX_W'(idx_inc);
        end else begin
          fill_nxt  = fill_r - bst_pkg::CNT_W'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    oldest_r <= oldest_nxt;
    hit_r    <= hit_nxt;
    drop_r   <= drop_nxt;
    if (in_fire) begin
      func_r <= in_ch.func;
      elem_r <= bst_pkg::ELEM_BITS'(in_ch.element);
    end
    if (out_load) begin
      out_was_member_r     <= hit_r;
      out_dropped_full_r   <= drop_r;
      out_set_count_r      <= bst_pkg::COUNT_W'(fill_r);
      out_is_empty_r       <= (fill_r == '0);
      out_oldest_element_r <= (fill_r == '0) ? '0 : bst_pkg::ELEM_IN_W'(oldest_r);
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.was_member     = out_was_member_r;
  assign out_ch.dropped_full   = out_dropped_full_r;
  assign out_ch.set_count      = out_set_count_r;
  assign out_ch.oldest_element = out_oldest_element_r;
  assign out_ch.is_empty       = out_is_empty_r;

endmodule

`default_nettype wire

@@ design/bst_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bst_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_was_member,
  input wire logic                          out_dropped_full,
  input wire logic [bst_pkg::COUNT_W-1:0]   out_set_count,
  input wire logic [bst_pkg::ELEM_IN_W-1:0] out_oldest_element,
  input wire logic                          out_is_empty
);

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_set_count == '0)))
    else $error("is_empty disagrees with set_count");

  a_empty_oldest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_oldest_element == '0))
    else $error("oldest_element nonzero on empty set");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_set_count <= bst_pkg::COUNT_W'(bst_pkg::CAPACITY)))
    else $error("set_count above capacity");

  a_drop_only_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_full) |->
      (!out_was_member && (out_set_count == bst_pkg::COUNT_W'(bst_pkg::CAPACITY))))
    else $error("dropped_full without a full table miss");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat withdrawn while stalled");

endmodule

bind bounded_set_table_unit bst_checker u_bst_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_was_member     (out_ch.was_member),
  .out_dropped_full   (out_ch.dropped_full),
  .out_set_count      (out_ch.set_count),
  .out_oldest_element (out_ch.oldest_element),
  .out_is_empty       (out_ch.is_empty)
);

`default_nettype wire
